FILE: sv/cmtc_pkg.sv
// Shared types and constants for the masked CAN trigger counter.
`timescale 1ns / 1ps
`default_nettype none

package cmtc_pkg;

  localparam int RULE_SLOTS_DEF = 32;
  localparam int MAX_CHECKED    = 32;
  localparam int CNT_W          = 6;
  localparam int SLOT_W         = 5;
  localparam int ID_W           = 29;
  localparam int DLC_W          = 4;
  localparam int DATA_W         = 64;
  localparam int BYTES          = 8;
  localparam int NEED_W         = 8;
  localparam int WIN_W          = 16;
  localparam int TIME_W         = 32;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [DATA_W-1:0] pattern;
    logic [DATA_W-1:0] mask;
    logic [NEED_W-1:0] needed;
    logic [WIN_W-1:0]  window;
  } rule_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
    logic [TIME_W-1:0] now;
  } frame_t;

  typedef struct packed {
    logic              hit;
    logic              expired;
    logic [SLOT_W-1:0] slot;
    logic [NEED_W-1:0] count;
    logic [TIME_W-1:0] start;
    logic [NEED_W-1:0] needed;
  } upd_t;

endpackage

`default_nettype wire

FILE: sv/cmtc_rule_store.sv
// Rule table memory: one write port for loads, one registered read port for the walk.
`timescale 1ns / 1ps
`default_nettype none

module cmtc_rule_store #(
  parameter int RULE_SLOTS = cmtc_pkg::RULE_SLOTS_DEF,
  parameter int IDX_W      = 5
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [IDX_W-1:0]     waddr,
  input  cmtc_pkg::rule_t     wdata,
  input  wire                 re,
  input  wire [IDX_W-1:0]     raddr,
  output cmtc_pkg::rule_t     rdata
);

  cmtc_pkg::rule_t mem [RULE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmtc_hit_store.sv
// Hit counter and window start memory; entries never written read as zero.
`timescale 1ns / 1ps
`default_nettype none

module cmtc_hit_store #(
  parameter int RULE_SLOTS = cmtc_pkg::RULE_SLOTS_DEF,
  parameter int IDX_W      = 5
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           we,
  input  wire [IDX_W-1:0]               waddr,
  input  wire [cmtc_pkg::NEED_W-1:0]    wcount,
  input  wire [cmtc_pkg::TIME_W-1:0]    wstart,
  input  wire                           re,
  input  wire [IDX_W-1:0]               raddr,
  output logic [cmtc_pkg::NEED_W-1:0]   rcount,
  output logic [cmtc_pkg::TIME_W-1:0]   rstart
);

  logic [cmtc_pkg::NEED_W-1:0] count_mem [RULE_SLOTS];
  logic [cmtc_pkg::TIME_W-1:0] start_mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0]       written;
  logic [cmtc_pkg::NEED_W-1:0] count_q;
  logic [cmtc_pkg::TIME_W-1:0] start_q;
  logic                        written_q;

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr] <= wcount;
      start_mem[waddr] <= wstart;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      count_q   <= count_mem[raddr];
      start_q   <= start_mem[raddr];
      written_q <= written[raddr];
    end
  end

  // One valid bit per slot gives the all-zero reset without a clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  assign rcount = written_q ? count_q : '0;
  assign rstart = written_q ? start_q : '0;

endmodule

`default_nettype wire

FILE: sv/cmtc_match.sv
// Shared compare unit: identifier, masked data and window age, one rule per cycle while en.
`timescale 1ns / 1ps
`default_nettype none

module cmtc_match #(
  parameter int IDX_W = 5
) (
  input  wire                            clk,
  input  wire                            en,
  input  cmtc_pkg::frame_t               frame,
  input  cmtc_pkg::rule_t                rule,
  input  wire [cmtc_pkg::NEED_W-1:0]     count,
  input  wire [cmtc_pkg::TIME_W-1:0]     start,
  input  wire [cmtc_pkg::SLOT_W-1:0]     slot_in,
  input  wire [IDX_W-1:0]                addr_in,
  output cmtc_pkg::upd_t                 upd,
  output logic [IDX_W-1:0]               addr_out
);

  localparam int DW = cmtc_pkg::DLC_W;
  localparam int TW = cmtc_pkg::TIME_W;

  logic [cmtc_pkg::BYTES-1:0]  byte_en;
  logic [cmtc_pkg::DATA_W-1:0] sel;
  logic [TW-1:0]               age;
  logic                        id_eq;
  logic                        data_eq;
  logic                        expired;

  // Bytes at or above the data length code take no part in the compare.
  always_comb begin
    for (int i = 0; i < cmtc_pkg::BYTES; i++) begin
      byte_en[i]    = frame.dlc > DW'(i);
      sel[8*i +: 8] = {8{byte_en[i]}};
    end
    id_eq   = frame.ident == rule.ident;
    data_eq = ((frame.data ^ rule.pattern) & rule.mask & sel) == '0;
    age     = frame.now - start;
    expired = age > TW'(rule.window);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      upd.hit     <= id_eq && data_eq;
      upd.expired <= expired;
      upd.slot    <= slot_in;
      upd.count   <= count;
      upd.start   <= start;
      upd.needed  <= rule.needed;
      addr_out    <= addr_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/can_masked_trigger_counter.sv
// Top level of the masked CAN trigger counter: sequencer, hit update and result queue.
//
// Usage. Items arrive on the input channel (in_valid / in_stall). A load item
// (kind = 1) writes one rule slot and gives no result; the block takes the
// next item in the following cycle. A frame item (kind = 0) is walked against
// rules 0 .. active_rules-1 (capped at the slot count and at 32) by one shared
// compare unit, one rule per cycle while the walk is not frozen, through a
// three-step pipeline: table read, compare, counter update. Through the walk
// and the drain that follows it the block is busy with the frame; in_stall
// stays high meanwhile. Every rule that fires gives one request on the output
// channel (out_valid / out_stall) carrying its index, in index order, and the
// last request of a frame carries last_of_run. One fired index is held back
// until the next one (or the end of the walk) shows whether it is the last.
// When the receiver stalls with a result waiting and another rule fires, the
// walk freezes in place until the output register frees up; at the end of the
// walk the block also waits until the held-back index fits into the output
// register. The user must write active_rules (cfg_valid / cfg_ready, always ready)
// only while idle; the block itself does not enforce this. Reset is synchronous:
// it clears active_rules, every hit counter and window start, and any request
// in flight; rule tables keep whatever they held and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module can_masked_trigger_counter #(
  parameter int RULE_SLOTS = cmtc_pkg::RULE_SLOTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [cmtc_pkg::CNT_W-1:0]       cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             kind,
  input  wire [cmtc_pkg::SLOT_W-1:0]      rule_index,
  input  wire [cmtc_pkg::ID_W-1:0]        can_id,
  input  wire [cmtc_pkg::DLC_W-1:0]       dlc,
  input  wire [cmtc_pkg::DATA_W-1:0]      payload,
  input  wire [cmtc_pkg::DATA_W-1:0]      byte_mask,
  input  wire [cmtc_pkg::NEED_W-1:0]      hits_needed,
  input  wire [cmtc_pkg::WIN_W-1:0]       window_len,
  input  wire [cmtc_pkg::TIME_W-1:0]      time_ms,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [cmtc_pkg::SLOT_W-1:0]     fired_rule,
  output logic                            last_of_run
);

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CAP   = (RULE_SLOTS < cmtc_pkg::MAX_CHECKED) ? RULE_SLOTS
                                                               : cmtc_pkg::MAX_CHECKED;
  localparam int CW    = cmtc_pkg::CNT_W;
  localparam int AW    = (IDX_W > CW) ? IDX_W : CW;
  localparam int LW    = (IDX_W > cmtc_pkg::SLOT_W) ? IDX_W : cmtc_pkg::SLOT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                    state;
  logic [CW-1:0]                 active_rules;
  logic [CW-1:0]                 lim_now;
  logic [CW-1:0]                 limit_q;
  logic [CW-1:0]                 issued;
  cmtc_pkg::frame_t              frame_q;

  logic                          in_take;
  logic                          load_we;
  logic [LW-1:0]                 load_ext;
  cmtc_pkg::rule_t               load_rule;
  logic [AW-1:0]                 issue_ext;
  logic [IDX_W-1:0]              issue_addr;
  logic                          issue_en;
  logic                          adv;

  cmtc_pkg::rule_t               rule_rd;
  logic [cmtc_pkg::NEED_W-1:0]   count_rd;
  logic [cmtc_pkg::TIME_W-1:0]   start_rd;

  logic                          v1;
  logic [cmtc_pkg::SLOT_W-1:0]   slot1;
  logic [IDX_W-1:0]              addr1;
  logic                          v2;
  cmtc_pkg::upd_t                upd;
  logic [IDX_W-1:0]              addr2;

  logic [cmtc_pkg::NEED_W-1:0]   base;
  logic [cmtc_pkg::NEED_W-1:0]   cnt_inc;
  logic                          matched;
  logic                          fire_now;
  logic                          upd_we;
  logic [cmtc_pkg::NEED_W-1:0]   wcount;
  logic [cmtc_pkg::TIME_W-1:0]   wstart;

  logic                          pend_valid;
  logic [cmtc_pkg::SLOT_W-1:0]   pend_slot;
  logic                          out_free;
  logic                          out_take;
  logic                          push_mid;
  logic                          push_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != ST_IDLE;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rules <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_rules <= cfg_data;
    end
  end

  assign lim_now = (active_rules > CW'(CAP)) ? CW'(CAP) : active_rules;

  // Loads go straight to the rule tables; slots beyond the table are dropped.
  assign load_ext  = LW'(rule_index);
  assign load_we   = in_take && kind && (32'(rule_index) < RULE_SLOTS);
  assign load_rule = '{ident: can_id, pattern: payload, mask: byte_mask,
                       needed: hits_needed, window: window_len};

  assign issue_ext  = AW'(issued);
  assign issue_addr = issue_ext[IDX_W-1:0];

  // The output register must be free whenever a held-back index is pushed out.
  assign out_free = !out_valid || !out_stall;
  assign out_take = out_valid && !out_stall;

  // Update step: restart the window if it has run out, count the hit, and fire.
  always_comb begin
    base     = upd.expired ? '0 : upd.count;
    cnt_inc  = base + 1'b1;
    matched  = v2 && upd.hit;
    fire_now = matched && (cnt_inc >= upd.needed);
    wcount   = fire_now ? '0 : cnt_inc;
    wstart   = upd.expired ? frame_q.now : upd.start;
  end

  // The whole walk holds still when a second index fires while the output is stalled.
  assign adv       = !(fire_now && pend_valid && !out_free);
  assign issue_en  = (state == ST_WALK) && (issued < limit_q) && adv;
  assign upd_we    = matched && adv;
  assign push_mid  = (state == ST_WALK) && fire_now && pend_valid && adv;
  assign push_last = (state == ST_DRAIN) && pend_valid && out_free;

  cmtc_rule_store #(
    .RULE_SLOTS (RULE_SLOTS),
    .IDX_W      (IDX_W)
  ) u_rules (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_ext[IDX_W-1:0]),
    .wdata (load_rule),
    .re    (adv),
    .raddr (issue_addr),
    .rdata (rule_rd)
  );

  cmtc_hit_store #(
    .RULE_SLOTS (RULE_SLOTS),
    .IDX_W      (IDX_W)
  ) u_hits (
    .clk    (clk),
    .rst    (rst),
    .we     (upd_we),
    .waddr  (addr2),
    .wcount (wcount),
    .wstart (wstart),
    .re     (adv),
    .raddr  (issue_addr),
    .rcount (count_rd),
    .rstart (start_rd)
  );

  cmtc_match #(
    .IDX_W (IDX_W)
  ) u_match (
    .clk      (clk),
    .en       (adv),
    .frame    (frame_q),
    .rule     (rule_rd),
    .count    (count_rd),
    .start    (start_rd),
    .slot_in  (slot1),
    .addr_in  (addr1),
    .upd      (upd),
    .addr_out (addr2)
  );

  // Sequencer and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      if (adv) begin
        v1 <= issue_en;
        v2 <= v1;
      end
      if (issue_en) begin
        issued <= issued + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take && !kind) begin
            issued <= '0;
            state  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if ((issued == limit_q) && !v1 && !v2) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pend_valid || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !kind) begin
      frame_q <= '{ident: can_id, dlc: dlc, data: payload, now: time_ms};
      limit_q <= lim_now;
    end
    if (issue_en) begin
      slot1 <= issued[cmtc_pkg::SLOT_W-1:0];
      addr1 <= issue_addr;
    end
  end

  // Held-back index and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire_now && adv) begin
        pend_valid <= 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_now && adv) begin
      pend_slot <= upd.slot;
    end
    if (push_mid || push_last) begin
      fired_rule  <= pend_slot;
      last_of_run <= push_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmtc_checker.sv
// Port-level checker for the masked CAN trigger counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cmtc_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          kind,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [cmtc_pkg::SLOT_W-1:0]   fired_rule,
  input wire                          last_of_run
);

  // A stalled result request holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fired_rule) && $stable(last_of_run))
    else $error("stalled result changed");

  // A frame occupies the block after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !kind |=> in_stall)
    else $error("frame accepted without going busy");

  // A rule load does not leave the block busy.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind |=> !in_stall)
    else $error("rule load left the block busy");

  // Results only appear while a frame is in work (walk or drain).
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result request without a frame in work");

endmodule

bind can_masked_trigger_counter cmtc_checker u_cmtc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .fired_rule  (fired_rule),
  .last_of_run (last_of_run)
);

`default_nettype wire
